>>> sv/rrw_pkg.sv
package rrw_pkg;

    localparam int SLOTS   = 32;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int WIN_W   = 5;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [WIN_W-1:0]     WIN_RESET       = 5'd31;
    localparam logic [PADDR_W-3:0]   REG_WINDOW_SIZE = '0;

    typedef enum logic {
        KIND_STATUS  = 1'b0,
        KIND_RELEASE = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_ACCEPTED  = 2'd0,
        ST_OUTSIDE   = 2'd1,
        ST_DUPLICATE = 2'd2
    } t_status;

    typedef struct packed {
        logic [31:0] msg_no;
        logic [31:0] seq_no;
        logic [15:0] payload_len;
        logic [15:0] block_tag;
    } t_in_word;

    typedef struct packed {
        t_kind       kind;
        t_status     status;
        logic [31:0] out_msg_no;
        logic [31:0] out_seq_no;
        logic [15:0] out_len;
        logic [15:0] out_tag;
        logic [31:0] expected_next;
        logic        last;
    } t_out_word;

    typedef struct packed {
        logic [31:0] seq_no;
        logic [15:0] len;
        logic [15:0] tag;
    } t_record;

endpackage

>>> sv/receive_reorder_window.sv
// channel    | signals                              | role
// -----------+--------------------------------------+---------------------------------
// in         | i_in_valid, o_in_ready, i_in_data     | arriving message word
// out        | o_out_valid, i_out_ready, o_out_data  | status word, then released words
// config     | psel, penable, pwrite, paddr, pwdata, | window_size at byte address 0
//            | prdata, pready                        |
//
// an accepted word passes capture, check, count, sum and emit up to its status word
// a rejected word skips count and sum
// each released entry then passes a record memory read step and an emit step
// output stalls hold the status and release emits until the output is free
// synchronous active-low reset clears window start, high mark and valid map, window_size to 31
// the record memory has no reset; only slots with a set valid bit are ever released
module receive_reorder_window (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  rrw_pkg::t_in_word                i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output rrw_pkg::t_out_word               o_out_data,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rrw_pkg::PADDR_W-1:0]      paddr,
    input  logic [rrw_pkg::PDATA_W-1:0]      pwdata,
    output logic [rrw_pkg::PDATA_W-1:0]      prdata,
    output logic                             pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_COUNT,
        S_SUM,
        S_STATUS,
        S_READ,
        S_RELEASE
    } t_state;

    t_state                          r_state;
    rrw_pkg::t_in_word               r_in;
    rrw_pkg::t_status                r_status;
    logic [31:0]                     r_ws;
    logic [rrw_pkg::SLOT_W-1:0]      r_ws_slot;
    logic [31:0]                     r_hm;
    logic [rrw_pkg::SLOTS-1:0]       r_valid;
    logic [rrw_pkg::WIN_W-1:0]       r_window_size;
    logic [rrw_pkg::CNT_W-1:0]       r_run;
    logic [rrw_pkg::CNT_W-1:0]       r_cap;
    logic [rrw_pkg::CNT_W-1:0]       r_cnt;
    logic [31:0]                     r_exp;
    logic                            r_out_valid;
    rrw_pkg::t_out_word              r_out;
    rrw_pkg::t_record                r_rd_data;
    rrw_pkg::t_record                mem [rrw_pkg::SLOTS];

    logic [31:0]                     eff;
    logic [31:0]                     off;
    logic                            outside;
    logic [rrw_pkg::SLOT_W:0]        slot_sum;
    logic [rrw_pkg::SLOT_W-1:0]      in_slot;
    logic                            dup;
    logic                            wr_en;
    logic [rrw_pkg::CNT_W-1:0]       run;
    logic [rrw_pkg::CNT_W-1:0]       cap;
    logic [31:0]                     hm_diff;
    logic [rrw_pkg::CNT_W-1:0]       cnt;
    logic                            out_free;
    logic                            emit;
    logic                            cfg_wr;
    logic [rrw_pkg::SLOT_W-1:0]      ws_slot_inc;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign pready      = 1'b1;
    assign out_free    = !r_out_valid || i_out_ready;
    assign emit        = ((r_state == S_STATUS) || (r_state == S_RELEASE)) && out_free;

    assign cfg_wr = psel && penable && pwrite
                    && (paddr[rrw_pkg::PADDR_W-1:2] == rrw_pkg::REG_WINDOW_SIZE);

    always_comb begin
        if (paddr[rrw_pkg::PADDR_W-1:2] == rrw_pkg::REG_WINDOW_SIZE) begin
            prdata = rrw_pkg::PDATA_W'(r_window_size);
        end else begin
            prdata = '0;
        end
    end

    // window check and slot of the arriving word
    assign eff = (32'(r_window_size) > 32'(rrw_pkg::SLOTS - 1))
                 ? 32'(rrw_pkg::SLOTS - 1) : 32'(r_window_size);
    assign off     = r_in.msg_no - r_ws;
    assign outside = (r_in.msg_no < r_ws) || (off > eff);
    assign slot_sum = {1'b0, r_ws_slot} + {1'b0, off[rrw_pkg::SLOT_W-1:0]};

    always_comb begin
        if (slot_sum >= (rrw_pkg::SLOT_W + 1)'(rrw_pkg::SLOTS)) begin
            in_slot = rrw_pkg::SLOT_W'(slot_sum - (rrw_pkg::SLOT_W + 1)'(rrw_pkg::SLOTS));
        end else begin
            in_slot = slot_sum[rrw_pkg::SLOT_W-1:0];
        end
    end

    assign dup   = r_valid[in_slot];
    assign wr_en = (r_state == S_CHECK) && !outside && !dup;

    // length of the held run starting at the window start
    always_comb begin
        logic [rrw_pkg::SLOT_W:0] t;
        logic                     found;
        run   = rrw_pkg::CNT_W'(rrw_pkg::SLOTS);
        found = 1'b0;
        for (int d = 0; d < rrw_pkg::SLOTS; d++) begin
            t = {1'b0, r_ws_slot} + (rrw_pkg::SLOT_W + 1)'(d);
            if (t >= (rrw_pkg::SLOT_W + 1)'(rrw_pkg::SLOTS)) begin
                t = t - (rrw_pkg::SLOT_W + 1)'(rrw_pkg::SLOTS);
            end
            if (!found && !r_valid[t[rrw_pkg::SLOT_W-1:0]]) begin
                run   = rrw_pkg::CNT_W'(d);
                found = 1'b1;
            end
        end
    end

    assign hm_diff = r_hm - r_ws;

    always_comb begin
        if (r_ws < r_hm) begin
            if (hm_diff >= 32'(rrw_pkg::SLOTS)) begin
                cap = rrw_pkg::CNT_W'(rrw_pkg::SLOTS);
            end else begin
                cap = hm_diff[rrw_pkg::CNT_W-1:0];
            end
        end else begin
            cap = '0;
        end
    end

    assign cnt = (r_run < r_cap) ? r_run : r_cap;

    assign ws_slot_inc = (r_ws_slot == rrw_pkg::SLOT_W'(rrw_pkg::SLOTS - 1))
                         ? '0 : r_ws_slot + 1'b1;

    // record memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[in_slot] <= '{seq_no: r_in.seq_no, len: r_in.payload_len,
                              tag: r_in.block_tag};
        end
        r_rd_data <= mem[r_ws_slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_in          <= '0;
            r_status      <= rrw_pkg::ST_ACCEPTED;
            r_ws          <= '0;
            r_ws_slot     <= '0;
            r_hm          <= '0;
            r_valid       <= '0;
            r_window_size <= rrw_pkg::WIN_RESET;
            r_run         <= '0;
            r_cap         <= '0;
            r_cnt         <= '0;
            r_exp         <= '0;
            r_out_valid   <= 1'b0;
            r_out         <= '0;
        end else begin
            if (cfg_wr) begin
                r_window_size <= pwdata[rrw_pkg::WIN_W-1:0];
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in    <= i_in_data;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (outside) begin
                        r_status <= rrw_pkg::ST_OUTSIDE;
                        r_cnt    <= '0;
                        r_exp    <= r_ws;
                        r_state  <= S_STATUS;
                    end else if (dup) begin
                        r_status <= rrw_pkg::ST_DUPLICATE;
                        r_cnt    <= '0;
                        r_exp    <= r_ws;
                        r_state  <= S_STATUS;
                    end else begin
                        r_status         <= rrw_pkg::ST_ACCEPTED;
                        r_valid[in_slot] <= 1'b1;
                        if (r_in.msg_no >= r_hm) begin
                            r_hm <= r_in.msg_no + 32'd1;
                        end
                        r_state <= S_COUNT;
                    end
                end
                S_COUNT: begin
                    r_run   <= run;
                    r_cap   <= cap;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_cnt   <= cnt;
                    r_exp   <= r_ws + 32'(cnt);
                    r_state <= S_STATUS;
                end
                S_STATUS: begin
                    if (out_free) begin
                        r_out.kind          <= rrw_pkg::KIND_STATUS;
                        r_out.status        <= r_status;
                        r_out.out_msg_no    <= '0;
                        r_out.out_seq_no    <= '0;
                        r_out.out_len       <= '0;
                        r_out.out_tag       <= '0;
                        r_out.expected_next <= r_exp;
                        r_out.last          <= (r_cnt == '0);
                        r_state             <= (r_cnt == '0) ? S_IDLE : S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_RELEASE;
                end
                S_RELEASE: begin
                    if (out_free) begin
                        r_out.kind           <= rrw_pkg::KIND_RELEASE;
                        r_out.status         <= rrw_pkg::ST_ACCEPTED;
                        r_out.out_msg_no     <= r_ws;
                        r_out.out_seq_no     <= r_rd_data.seq_no;
                        r_out.out_len        <= r_rd_data.len;
                        r_out.out_tag        <= r_rd_data.tag;
                        r_out.expected_next  <= r_exp;
                        r_out.last           <= (r_cnt == rrw_pkg::CNT_W'(1));
                        r_valid[r_ws_slot]   <= 1'b0;
                        r_ws                 <= r_ws + 32'd1;
                        r_ws_slot            <= ws_slot_inc;
                        r_cnt                <= r_cnt - 1'b1;
                        r_state <= (r_cnt == rrw_pkg::CNT_W'(1)) ? S_IDLE : S_READ;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
